@@ rtl/gwf_pkg.sv @@
// ----------------------------------------------------------------------------
// gwf_pkg
// Shared types and constants for the grid water flow step block.
// ----------------------------------------------------------------------------
package gwf_pkg;

  localparam int LEVEL_BITS = 16;
  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = '1;

  // operation codes
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_STEP  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_WATER = 2'd0;
  localparam logic [1:0] CFG_MIN_WATER = 2'd1;

  localparam logic [LEVEL_BITS-1:0] MAX_WATER_RESET = 16'd4096;
  localparam logic [LEVEL_BITS-1:0] MIN_WATER_RESET = 16'd4;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [4:0]            cell_column;
    logic [4:0]            cell_row;
    logic                  solid_flag;
    logic [LEVEL_BITS-1:0] water_amount;
  } cmd_t;

  typedef struct packed {
    logic                  cell_is_solid;
    logic [LEVEL_BITS-1:0] cell_water;
    logic [2:0]            done_opcode;
  } rsp_t;

  // result of one side flow look
  typedef struct packed {
    logic [LEVEL_BITS-1:0] flow;
    logic [LEVEL_BITS-1:0] amount;
    logic                  drained;
  } side_t;

endpackage

@@ rtl/gwf_side_unit.sv @@
// ----------------------------------------------------------------------------
// gwf_side_unit
// Side flow unit shared by the left and right looks of a cell.
// ----------------------------------------------------------------------------
module gwf_side_unit (
  input  logic [gwf_pkg::LEVEL_BITS-1:0] amount,
  input  logic [gwf_pkg::LEVEL_BITS-1:0] neighbor,
  input  logic [gwf_pkg::LEVEL_BITS-1:0] min_water,
  output gwf_pkg::side_t                 result
);

  logic [gwf_pkg::LEVEL_BITS:0]   diff;
  logic [gwf_pkg::LEVEL_BITS-1:0] flow;
  logic [gwf_pkg::LEVEL_BITS-1:0] rem;

  // quarter of the positive excess over the neighbor
  assign diff = {1'b0, amount} - {1'b0, neighbor};
  assign flow = (!diff[gwf_pkg::LEVEL_BITS] && (diff != '0))
              ? {2'b00, diff[gwf_pkg::LEVEL_BITS-1:2]} : '0;
  assign rem  = amount - flow;

  // a small remainder is dropped and the cell stops
  assign result.flow    = flow;
  assign result.drained = (rem < min_water);
  assign result.amount  = (rem < min_water) ? '0 : rem;

endmodule

@@ rtl/grid_water_flow_step_top.sv @@
// ----------------------------------------------------------------------------
// grid_water_flow_step_top
// Water flow cellular automaton over a grid of solid and blank cells.
// ----------------------------------------------------------------------------
// One command is taken at a time; cmd_ready is high only when the sequencer
// is idle, and the response register lets a new command in while the last
// response waits. Write and unknown codes go straight to the response, read
// and add first read the cell, clear water zeroes the water of every cell.
// A step walks the cells through memories with one read and one write port:
// it reads a cell and its neighbors below, left and right; for a blank cell it
// computes the fill below and the left and right flows through the shared side
// flow unit and makes four change store read-modify-writes. A last pass applies
// the change store to all cells. After reset a clearing pass zeroes all memories
// before the first command is taken; configuration writes are taken at any time.
module grid_water_flow_step_top #(
  parameter int GRID_WIDTH  = 32,
  parameter int GRID_HEIGHT = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  gwf_pkg::cmd_t                  cmd,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output gwf_pkg::rsp_t                  rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [gwf_pkg::LEVEL_BITS-1:0] cfg_data
);

  localparam int LB         = gwf_pkg::LEVEL_BITS;
  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int IDX_BITS   = $clog2(CELL_COUNT);
  localparam int XB         = $clog2(GRID_WIDTH);
  localparam int YB         = $clog2(GRID_HEIGHT);
  localparam int CB         = LB + 2;

  localparam logic [4:0] ST_INIT  = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_CLR   = 5'd2;
  localparam logic [4:0] ST_OPRD  = 5'd3;
  localparam logic [4:0] ST_DONE  = 5'd4;
  localparam logic [4:0] ST_F0    = 5'd5;
  localparam logic [4:0] ST_F1    = 5'd6;
  localparam logic [4:0] ST_F2    = 5'd7;
  localparam logic [4:0] ST_F3    = 5'd8;
  localparam logic [4:0] ST_F4    = 5'd9;
  localparam logic [4:0] ST_FILL  = 5'd10;
  localparam logic [4:0] ST_LEFT  = 5'd11;
  localparam logic [4:0] ST_RIGHT = 5'd12;
  localparam logic [4:0] ST_CRD   = 5'd13;
  localparam logic [4:0] ST_CWR   = 5'd14;
  localparam logic [4:0] ST_ARD   = 5'd15;
  localparam logic [4:0] ST_AWR   = 5'd16;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CELL_COUNT - 1);

  // memories
  logic          smem [CELL_COUNT];
  logic [LB-1:0] wmem [CELL_COUNT];
  logic [CB-1:0] cmem [CELL_COUNT];

  logic [4:0]          state;
  logic [LB-1:0]       max_water;
  logic [LB-1:0]       min_water;
  logic [2:0]          op;
  logic [IDX_BITS-1:0] idx;
  logic                in_grid;
  logic [LB-1:0]       amt;
  logic [IDX_BITS-1:0] sweep;
  logic [IDX_BITS-1:0] me;
  logic [XB-1:0]       x;
  logic [YB-1:0]       y;
  logic                sme, sdn, sl, sr;
  logic [LB-1:0]       wme, wdn, wl, wr;
  logic [LB-1:0]       amount;
  logic [LB-1:0]       dfill, dl, dr;
  logic                drained;
  logic [1:0]          tgt;
  logic                res_solid;
  logic [LB-1:0]       res_water;

  logic                s_rd;
  logic [LB-1:0]       w_rd;
  logic [CB-1:0]       c_rd;
  logic [IDX_BITS-1:0] raddr, craddr, waddr, taddr;
  logic                s_we, w_we, c_we;
  logic                s_wdata;
  logic [LB-1:0]       w_wdata;
  logic [CB-1:0]       c_wdata;

  logic [IDX_BITS-1:0] cmd_idx;
  logic                cmd_inside;
  logic [IDX_BITS-1:0] dn_addr, l_addr, r_addr;
  logic                has_dn, has_l, has_r, last_cell;
  logic [LB:0]         fill_sum;
  logic [LB-1:0]       fill;
  logic [LB-1:0]       side_nbr;
  gwf_pkg::side_t      side;
  logic [CB-1:0]       delta;
  logic [LB:0]         add_sum;
  logic [CB:0]         apply_sum;
  logic [LB-1:0]       apply_lvl;

  assign cmd_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_water <= gwf_pkg::MAX_WATER_RESET;
      min_water <= gwf_pkg::MIN_WATER_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == gwf_pkg::CFG_MAX_WATER) max_water <= cfg_data;
      if (cfg_index == gwf_pkg::CFG_MIN_WATER) min_water <= cfg_data;
    end
  end

  // addressing
  assign cmd_inside = (32'(cmd.cell_column) < GRID_WIDTH) && (32'(cmd.cell_row) < GRID_HEIGHT);
  assign cmd_idx    = IDX_BITS'(32'(cmd.cell_row) * GRID_WIDTH + 32'(cmd.cell_column));
  assign dn_addr    = me - IDX_BITS'(GRID_WIDTH);
  assign l_addr     = me - IDX_BITS'(1);
  assign r_addr     = me + IDX_BITS'(1);
  assign has_dn     = (y != '0);
  assign has_l      = (x != '0);
  assign has_r      = (x != XB'(GRID_WIDTH - 1));
  assign last_cell  = (x == XB'(GRID_WIDTH - 1)) && (y == YB'(GRID_HEIGHT - 1));

  // fill of the cell below
  assign fill_sum = {1'b0, wdn} + {1'b0, wme};
  always_comb begin
    fill = '0;
    if (has_dn && !sdn && (wdn < max_water)) begin
      fill = (fill_sum < {1'b0, max_water}) ? wme : (max_water - wdn);
    end
  end

  // shared side flow unit
  assign side_nbr = (state == ST_LEFT) ? wl : wr;
  gwf_side_unit u_side (
    .amount    (amount),
    .neighbor  (side_nbr),
    .min_water (min_water),
    .result    (side)
  );

  // change target of the current transaction
  always_comb begin
    case (tgt)
      2'd0:    begin taddr = me;      delta = {2'b00, amount} - {2'b00, wme}; end
      2'd1:    begin taddr = dn_addr; delta = {2'b00, dfill}; end
      2'd2:    begin taddr = l_addr;  delta = {2'b00, dl}; end
      default: begin taddr = r_addr;  delta = {2'b00, dr}; end
    endcase
  end

  assign add_sum   = {1'b0, w_rd} + {1'b0, amt};
  assign apply_sum = {3'b000, w_rd} + {c_rd[CB-1], c_rd};
  assign apply_lvl = apply_sum[CB] ? '0
                   : ((apply_sum[CB-1:LB] != '0) ? gwf_pkg::FULL_SCALE : apply_sum[LB-1:0]);

  // memory port selection
  always_comb begin
    raddr   = cmd_idx;
    craddr  = taddr;
    waddr   = sweep;
    s_we    = 1'b0;
    w_we    = 1'b0;
    c_we    = 1'b0;
    s_wdata = 1'b0;
    w_wdata = '0;
    c_wdata = '0;
    unique case (state)
      ST_INIT: begin
        s_we = 1'b1;
        w_we = 1'b1;
        c_we = 1'b1;
      end
      ST_IDLE: begin
        waddr   = cmd_idx;
        s_wdata = cmd.solid_flag;
        w_wdata = cmd.water_amount;
        s_we    = cmd_valid && cmd_inside && (cmd.opcode == gwf_pkg::OP_WRITE);
        w_we    = s_we;
      end
      ST_CLR:  w_we = 1'b1;
      ST_OPRD: begin
        waddr   = idx;
        w_wdata = add_sum[LB] ? gwf_pkg::FULL_SCALE : add_sum[LB-1:0];
        w_we    = (op == gwf_pkg::OP_ADD) && in_grid && !s_rd && (w_rd < max_water);
      end
      ST_F0:   raddr = me;
      ST_F1:   raddr = dn_addr;
      ST_F2:   raddr = l_addr;
      ST_F3:   raddr = r_addr;
      ST_CWR: begin
        waddr   = taddr;
        c_wdata = c_rd + delta;
        c_we    = (delta != '0);
      end
      ST_ARD: begin
        raddr  = sweep;
        craddr = sweep;
      end
      ST_AWR: begin
        w_wdata = apply_lvl;
        w_we    = 1'b1;
        c_we    = 1'b1;
      end
      default: ;
    endcase
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    s_rd <= smem[raddr];
    w_rd <= wmem[raddr];
    c_rd <= cmem[craddr];
    if (s_we) smem[waddr] <= s_wdata;
    if (w_we) wmem[waddr] <= w_wdata;
    if (c_we) cmem[waddr] <= c_wdata;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != ST_DONE)) rsp_valid <= 1'b0;
      unique case (state)
        ST_INIT, ST_CLR: begin
          sweep <= sweep + IDX_BITS'(1);
          if (sweep == LAST_IDX) state <= (state == ST_INIT) ? ST_IDLE : ST_DONE;
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            op        <= cmd.opcode;
            idx       <= cmd_idx;
            in_grid   <= cmd_inside;
            amt       <= cmd.water_amount;
            res_solid <= 1'b0;
            res_water <= '0;
            sweep     <= '0;
            me        <= '0;
            x         <= '0;
            y         <= '0;
            case (cmd.opcode)
              gwf_pkg::OP_ADD, gwf_pkg::OP_READ: state <= ST_OPRD;
              gwf_pkg::OP_STEP:                  state <= ST_F0;
              gwf_pkg::OP_CLEAR:                 state <= ST_CLR;
              default:                           state <= ST_DONE;
            endcase
          end
        end
        ST_OPRD: begin
          if ((op == gwf_pkg::OP_READ) && in_grid) begin
            res_solid <= s_rd;
            res_water <= w_rd;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.cell_is_solid <= res_solid;
            rsp.cell_water    <= res_water;
            rsp.done_opcode   <= op;
            state             <= ST_IDLE;
          end
        end
        ST_F0: state <= ST_F1;
        ST_F1: begin
          sme   <= s_rd;
          wme   <= w_rd;
          state <= ST_F2;
        end
        ST_F2: begin
          sdn   <= s_rd;
          wdn   <= w_rd;
          state <= ST_F3;
        end
        ST_F3: begin
          sl    <= s_rd;
          wl    <= w_rd;
          state <= ST_F4;
        end
        ST_F4: begin
          sr    <= s_rd;
          wr    <= w_rd;
          state <= ST_FILL;
        end
        ST_FILL: begin
          amount  <= wme - fill;
          dfill   <= fill;
          drained <= 1'b0;
          if (sme) begin
            // solid cell: on to the next one
            if (last_cell) begin
              state <= ST_ARD;
            end else begin
              state <= ST_F0;
              me    <= me + IDX_BITS'(1);
              x     <= has_r ? x + XB'(1) : '0;
              if (!has_r) y <= y + YB'(1);
            end
          end else begin
            state <= ST_LEFT;
          end
        end
        ST_LEFT: begin
          if (has_l && !sl) begin
            dl      <= side.flow;
            amount  <= side.amount;
            drained <= side.drained;
          end else begin
            dl <= '0;
          end
          state <= ST_RIGHT;
        end
        ST_RIGHT: begin
          if (!drained && has_r && !sr) begin
            dr     <= side.flow;
            amount <= side.amount;
          end else begin
            dr <= '0;
          end
          tgt   <= 2'd0;
          state <= ST_CRD;
        end
        ST_CRD: state <= ST_CWR;
        ST_CWR: begin
          tgt <= tgt + 2'd1;
          if (tgt == 2'd3) begin
            if (last_cell) begin
              state <= ST_ARD;
            end else begin
              state <= ST_F0;
              me    <= me + IDX_BITS'(1);
              x     <= has_r ? x + XB'(1) : '0;
              if (!has_r) y <= y + YB'(1);
            end
          end else begin
            state <= ST_CRD;
          end
        end
        ST_ARD: state <= ST_AWR;
        ST_AWR: begin
          sweep <= sweep + IDX_BITS'(1);
          state <= (sweep == LAST_IDX) ? ST_DONE : ST_ARD;
        end
        default: state <= ST_INIT;
      endcase
    end
  end

endmodule

@@ rtl/gwf_checker.sv @@
// ----------------------------------------------------------------------------
// gwf_checker
// Port-level assertions for the grid water flow step block.
// ----------------------------------------------------------------------------
module gwf_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input gwf_pkg::rsp_t rsp
);

  // a waiting response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid && !cmd_ready)
    else $error("activity right after reset");

  // only reads carry cell data
  a_rd_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.done_opcode != gwf_pkg::OP_READ)
      |-> (rsp.cell_water == '0) && !rsp.cell_is_solid)
    else $error("cell data on a non-read response");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

endmodule

bind grid_water_flow_step_top gwf_checker u_gwf_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives cell writes, adds, reads, clears and flow steps into the water flow
// grid, predicts every response from a local model of the grid and compares
// each field, with random idle cycles on the command and response sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GW = 32;
  localparam int GH = 32;
  localparam int CELLS = GW * GH;
  localparam int WATCHDOG_LIMIT = 200000;

  // opcodes outside the defined set
  localparam logic [2:0] OP_BAD_FIRST = 3'd5;
  localparam logic [2:0] OP_BAD_LAST  = 3'd7;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  gwf_pkg::cmd_t cmd;
  logic rsp_valid;
  logic rsp_ready;
  gwf_pkg::rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [gwf_pkg::LEVEL_BITS-1:0] cfg_data;

  grid_water_flow_step_top #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // grid copy used for prediction
  bit            solid_q [CELLS];
  int            level_q [CELLS];
  longint        delta_q [CELLS];
  int            cap_level;
  int            drain_level;
  gwf_pkg::rsp_t rsp_expected [$];
  int            errors;
  int            steps_sent;
  int            reads_checked;
  int            idle_pct;
  int            quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int clamp_level(longint v);
    if (v < 0) return 0;
    if (v > longint'(gwf_pkg::FULL_SCALE)) return int'(gwf_pkg::FULL_SCALE);
    return int'(v);
  endfunction

  function automatic longint quarter_excess(longint amount, int idx);
    longint diff;
    diff = amount - level_q[idx];
    if (diff <= 0) return 0;
    return diff / 4;
  endfunction

  // one automaton step on the local grid
  function automatic void flow_grid();
    int me;
    longint amount;
    longint fl;
    longint below;
    for (int i = 0; i < CELLS; i++) delta_q[i] = 0;
    for (int y = 0; y < GH; y++) begin
      for (int x = 0; x < GW; x++) begin
        me = y * GW + x;
        if (solid_q[me]) continue;
        amount = level_q[me];
        if (y > 0) begin
          below = level_q[me - GW];
          if (!solid_q[me - GW] && below < cap_level) begin
            fl = (below + amount < cap_level) ? amount : (cap_level - below);
            amount -= fl;
            delta_q[me] -= fl;
            delta_q[me - GW] += fl;
          end
        end
        if (x > 0 && !solid_q[me - 1]) begin
          fl = quarter_excess(amount, me - 1);
          amount -= fl;
          delta_q[me] -= fl;
          delta_q[me - 1] += fl;
          if (amount < drain_level) begin
            delta_q[me] -= amount;
            continue;
          end
        end
        if (x + 1 < GW && !solid_q[me + 1]) begin
          fl = quarter_excess(amount, me + 1);
          amount -= fl;
          delta_q[me] -= fl;
          delta_q[me + 1] += fl;
          if (amount < drain_level) begin
            delta_q[me] -= amount;
            continue;
          end
        end
      end
    end
    for (int i = 0; i < CELLS; i++) level_q[i] = clamp_level(level_q[i] + delta_q[i]);
  endfunction

  // expected response of one command, updating the local grid
  function automatic gwf_pkg::rsp_t predict_cell_op(gwf_pkg::cmd_t c);
    gwf_pkg::rsp_t r;
    int idx;
    r = '0;
    r.done_opcode = c.opcode;
    idx = int'(c.cell_row) * GW + int'(c.cell_column);
    case (c.opcode)
      gwf_pkg::OP_WRITE: begin
        solid_q[idx] = c.solid_flag;
        level_q[idx] = int'(c.water_amount);
      end
      gwf_pkg::OP_ADD: begin
        if (!solid_q[idx] && level_q[idx] < cap_level)
          level_q[idx] = clamp_level(longint'(level_q[idx]) + longint'(c.water_amount));
      end
      gwf_pkg::OP_READ: begin
        r.cell_is_solid = solid_q[idx];
        r.cell_water = level_q[idx][gwf_pkg::LEVEL_BITS-1:0];
        reads_checked++;
      end
      gwf_pkg::OP_STEP: begin
        flow_grid();
        steps_sent++;
      end
      gwf_pkg::OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) level_q[i] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one command transaction; valid stays up until the next one or a drain
  task automatic send_cell_op(gwf_pkg::cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    rsp_expected.push_back(predict_cell_op(c));
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic send_op(logic [2:0] op, int col, int row, bit sf, int amt);
    gwf_pkg::cmd_t c;
    c.opcode = op;
    c.cell_column = col[4:0];
    c.cell_row = row[4:0];
    c.solid_flag = sf;
    c.water_amount = amt[gwf_pkg::LEVEL_BITS-1:0];
    send_cell_op(c);
  endtask

  // wait until all responses have arrived, then a quiet gap
  task automatic drain_responses();
    cmd_valid <= 1'b0;
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, int value);
    drain_responses();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value[gwf_pkg::LEVEL_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == gwf_pkg::CFG_MAX_WATER) cap_level = value;
    else drain_level = value;
  endtask

  // response side: random stalls, field compare
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_expected.size() == 0) begin
          $display("%0t: unexpected response %p", $time, rsp);
          errors++;
        end else begin
          if (rsp !== rsp_expected[0]) begin
            $display("%0t: response mismatch expected %p actual %p",
                     $time, rsp_expected[0], rsp);
            errors++;
          end
          void'(rsp_expected.pop_front());
        end
      end
      rsp_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_edges_and_ops();
    send_op(gwf_pkg::OP_READ, 0, 0, 0, 0);
    send_op(gwf_pkg::OP_WRITE, 31, 31, 1, 'hFFFF);
    send_op(gwf_pkg::OP_READ, 31, 31, 0, 0);
    send_op(gwf_pkg::OP_WRITE, 0, 1, 0, 'hFFFF);
    send_op(gwf_pkg::OP_WRITE, 0, 0, 0, 0);
    send_op(gwf_pkg::OP_ADD, 0, 0, 1, 'hFFFF);
    send_op(gwf_pkg::OP_ADD, 0, 0, 0, 'h1234);
    send_op(gwf_pkg::OP_WRITE, 5, 3, 1, 100);
    send_op(gwf_pkg::OP_ADD, 5, 3, 0, 100);
    send_op(gwf_pkg::OP_WRITE, 31, 2, 0, 9000);
    send_op(gwf_pkg::OP_WRITE, 30, 2, 0, 3);
    send_op(gwf_pkg::OP_STEP, 0, 0, 0, 0);
    send_op(gwf_pkg::OP_READ, 0, 0, 0, 0);
    send_op(gwf_pkg::OP_READ, 31, 1, 0, 0);
    send_op(gwf_pkg::OP_READ, 30, 2, 0, 0);
    send_op(OP_BAD_FIRST, 31, 31, 1, 'hFFFF);
    send_op(OP_BAD_LAST, 0, 0, 0, 0);
    send_op(gwf_pkg::OP_CLEAR, 0, 0, 0, 0);
    send_op(gwf_pkg::OP_READ, 31, 31, 0, 0);
  endtask

  // small pool of cells so writes, flows and reads meet each other
  task automatic test_random_grid(int count);
    int col;
    int row;
    int pick;
    for (int n = 0; n < count; n++) begin
      col = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(12, 4);
      row = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(4);
      pick = $urandom_range(99);
      if (pick < 30)
        send_op(gwf_pkg::OP_WRITE, col, row, $urandom_range(4) == 0,
                ($urandom_range(1) != 0) ? $urandom_range(16'hFFFF) : $urandom_range(8192));
      else if (pick < 45)
        send_op(gwf_pkg::OP_ADD, col, row, 1'($urandom_range(1)), $urandom_range(16'hFFFF));
      else if (pick < 80)
        send_op(gwf_pkg::OP_READ, col, row, 1'($urandom_range(1)), $urandom_range(16'hFFFF));
      else if (pick < 94)
        send_op(gwf_pkg::OP_STEP, col, row, 0, 0);
      else if (pick < 97)
        send_op(gwf_pkg::OP_CLEAR, col, row, 0, 0);
      else
        send_op(3'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST)), col, row,
                1'($urandom_range(1)), $urandom_range(16'hFFFF));
    end
  endtask

  initial begin
    errors = 0;
    steps_sent = 0;
    reads_checked = 0;
    idle_pct = 37;
    cap_level = int'(gwf_pkg::MAX_WATER_RESET);
    drain_level = int'(gwf_pkg::MIN_WATER_RESET);
    for (int i = 0; i < CELLS; i++) begin
      solid_q[i] = 1'b0;
      level_q[i] = 0;
    end
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = gwf_pkg::CFG_MAX_WATER;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edges_and_ops();
    test_random_grid(70);
    write_register(gwf_pkg::CFG_MAX_WATER, 'hFFFF);
    write_register(gwf_pkg::CFG_MIN_WATER, 0);
    idle_pct = 0;
    test_random_grid(60);
    idle_pct = 37;
    write_register(gwf_pkg::CFG_MAX_WATER, 0);
    write_register(gwf_pkg::CFG_MIN_WATER, 'hFFFF);
    test_random_grid(50);
    write_register(gwf_pkg::CFG_MAX_WATER, int'($urandom_range(16'hFFFF)));
    write_register(gwf_pkg::CFG_MIN_WATER, int'($urandom_range(200)));
    test_random_grid(60);
    write_register(gwf_pkg::CFG_MAX_WATER, 2048);
    write_register(gwf_pkg::CFG_MIN_WATER, 'h8000);
    test_random_grid(30);

    drain_responses();
    $display("covered cell write, add, read, clear, %0d flow steps and %0d reads",
             steps_sent, reads_checked);
    $display("under five register settings with random stalls on both sides");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/gwf_pkg.sv
rtl/gwf_side_unit.sv
rtl/grid_water_flow_step_top.sv
rtl/gwf_checker.sv
tb/testbench.sv
